@@ hdl/assert_macros.svh @@
// assertion macros shared by the allocator rtl
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bfa_pkg.sv @@
// types, codes and constants of the bitmap frame allocator
// no dependencies; used by the channel interfaces and all modules
package bfa_pkg;

   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = 5;
   localparam int FRAME_BYTES = 4096;
   localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
   localparam int FRAME_W     = 32 - FRAME_SHIFT;
   localparam int WORD_IDX_W  = FRAME_W - BIT_W;

   localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

   localparam logic [1:0] REQ_ALLOC     = 2'd0;
   localparam logic [1:0] REQ_FREE      = 2'd1;
   localparam logic [1:0] REQ_MARK_USED = 2'd2;
   localparam logic [1:0] REQ_MARK_FREE = 2'd3;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_OOM         = 3'd1;
   localparam logic [2:0] STATUS_MISALIGNED  = 3'd2;
   localparam logic [2:0] STATUS_DOUBLE_FREE = 3'd3;
   localparam logic [2:0] STATUS_RANGE       = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DONE
   } bfa_state_type;

   // position of the lowest clear bit; only meaningful if the word is not full
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ hdl/bfa_if.sv @@
// valid/ready channel interfaces for request and response words
// depends on bfa_pkg
interface bfa_req_if
   import bfa_pkg::*;
;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] frame_addr;

   modport source (output valid, output req_type, output frame_addr, input ready);
   modport sink (input valid, input req_type, input frame_addr, output ready);
endinterface

interface bfa_rsp_if
   import bfa_pkg::*;
;
   logic        valid;
   logic        ready;
   logic [31:0] result_addr;
   logic [2:0]  status;

   modport source (output valid, output result_addr, output status, input ready);
   modport sink (input valid, input result_addr, input status, output ready);
endinterface

@@ hdl/bitmap_frame_allocator_top.sv @@
// channel   | dir | words carried
// req_ch    | in  | req_type, frame_addr
// rsp_ch    | out | result_addr, status (one response per request)
//
// alloc: one bitmap word read per cycle from word 0
// free, mark used, mark free: read word, modify and write back, respond
// after reset a clearing pass writes all ones into every word,
// with req_ch.ready low throughout
// one request in flight; a new request is taken while the last response waits
// depends on bfa_pkg, bfa_if, bfa_bitmap_ram and assert_macros.svh
`include "assert_macros.svh"

module bitmap_frame_allocator_top
   import bfa_pkg::*;
#(
   parameter int BITMAP_WORDS = 1024
) (
   input logic       clock,
   input logic       reset,
   bfa_req_if.sink   req_ch,
   bfa_rsp_if.source rsp_ch
);

   localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam logic [WW-1:0] LAST_WORD = WW'(BITMAP_WORDS - 1);
   localparam logic [WORD_IDX_W:0] WORD_LIMIT = (WORD_IDX_W + 1)'(BITMAP_WORDS);

   bfa_state_type state_ff, state_in;

   logic [WW-1:0]        clr_ptr_ff, clr_ptr_in;
   logic [WW-1:0]        word_ff, word_in;
   logic [1:0]           kind_ff;
   logic [31:0]          addr_ff;
   logic [31:0]          res_addr_ff, res_addr_in;
   logic [2:0]           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;

   logic                 req_accept;
   logic [WORD_IDX_W-1:0] in_word_idx;
   logic                 in_range;
   logic [WORD_IDX_W-1:0] cur_word_idx;
   logic                 cur_in_range;
   logic [BIT_W-1:0]     cur_bit;
   logic [WORD_BITS-1:0] cur_mask;
   logic [BIT_W-1:0]     hit_bit;
   logic [FRAME_W-1:0]   hit_frame;
   logic                 word_full;
   logic                 slot_free;

   logic                 mem_wr_en;
   logic [WW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [WW-1:0]        mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   bfa_bitmap_ram #(
      .DEPTH  (BITMAP_WORDS),
      .ADDR_W (WW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign in_word_idx  = req_ch.frame_addr[31 -: WORD_IDX_W];
   assign in_range     = {1'b0, in_word_idx} < WORD_LIMIT;
   assign cur_word_idx = addr_ff[31 -: WORD_IDX_W];
   assign cur_in_range = {1'b0, cur_word_idx} < WORD_LIMIT;
   assign cur_bit      = addr_ff[FRAME_SHIFT +: BIT_W];
   assign cur_mask     = WORD_BITS'(1) << cur_bit;
   assign word_full    = mem_rd_data == FULL_WORD;
   assign hit_bit      = lowest_clear(mem_rd_data);
   assign hit_frame    = {WORD_IDX_W'(word_ff), hit_bit};
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready       = state_ff == ST_IDLE;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;
   assign rsp_ch.status      = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_ch.req_type == REQ_ALLOC) ? ST_SCAN : ST_CHECK;
            end
         end
         ST_SCAN: begin
            if (!word_full || word_ff == LAST_WORD) begin
               state_in = ST_DONE;
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      mem_wr_en     = 1'b0;
      mem_wr_addr   = word_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = word_ff;
      clr_ptr_in    = clr_ptr_ff;
      word_in       = word_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ptr_ff;
            mem_wr_data = FULL_WORD;
            clr_ptr_in  = clr_ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_accept) begin
               mem_rd_en = 1'b1;
               if (req_ch.req_type == REQ_ALLOC) begin
                  mem_rd_addr = '0;
               end else if (in_range) begin
                  mem_rd_addr = in_word_idx[WW-1:0];
               end else begin
                  mem_rd_addr = '0;
               end
               word_in = mem_rd_addr;
            end
         end
         ST_SCAN: begin
            // if this word is full and not the last, read of the following word is issued while this one is examined
            if (!word_full) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = mem_rd_data | (WORD_BITS'(1) << hit_bit);
               res_addr_in   = {hit_frame, {FRAME_SHIFT{1'b0}}};
               res_status_in = STATUS_OK;
            end else if (word_ff == LAST_WORD) begin
               res_addr_in   = '0;
               res_status_in = STATUS_OOM;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = word_ff + 1'b1;
               word_in     = mem_rd_addr;
            end
         end
         ST_CHECK: begin
            res_addr_in   = '0;
            res_status_in = STATUS_OK;
            if (kind_ff == REQ_FREE && addr_ff[FRAME_SHIFT-1:0] != '0) begin
               res_status_in = STATUS_MISALIGNED;
            end else if (!cur_in_range) begin
               res_status_in = STATUS_RANGE;
            end else begin
               case (kind_ff)
                  REQ_FREE: begin
                     if ((mem_rd_data & cur_mask) == '0) begin
                        res_status_in = STATUS_DOUBLE_FREE;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data & ~cur_mask;
                     end
                  end
                  REQ_MARK_USED: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = mem_rd_data | cur_mask;
                  end
                  REQ_MARK_FREE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = mem_rd_data & ~cur_mask;
                  end
                  default: begin
                     mem_wr_en = 1'b0;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (req_accept) begin
         kind_ff <= req_ch.req_type;
         addr_ff <= req_ch.frame_addr;
      end
   end

   `BFA_ASSERT_NOW(a_wr_only_when_busy, clock, reset, mem_wr_en,
      state_ff == ST_CLEAR || state_ff == ST_SCAN || state_ff == ST_CHECK,
      "bitmap written outside clear, scan or check")
   `BFA_ASSERT_NOW(a_scan_in_bounds, clock, reset, state_ff == ST_SCAN,
      word_ff <= LAST_WORD, "scan pointer beyond the bitmap")
   `BFA_ASSERT_NOW(a_oom_zero_addr, clock, reset,
      rsp_valid_ff && rsp_status_ff == STATUS_OOM, rsp_addr_ff == '0,
      "out of memory response with a non-zero address")
   `BFA_ASSERT_NOW(a_addr_only_on_ok, clock, reset,
      rsp_valid_ff && rsp_addr_ff != '0, rsp_status_ff == STATUS_OK,
      "address returned with an error status")
   `BFA_ASSERT_NEXT(a_clear_ends, clock, reset,
      state_ff == ST_CLEAR && clr_ptr_ff == LAST_WORD, state_ff == ST_IDLE,
      "clearing pass did not end after the last word")

endmodule

@@ hdl/bfa_bitmap_ram.sv @@
// single-port-write, single-port-read bitmap memory with registered read data
// depends on bfa_pkg for the word width
module bfa_bitmap_ram
   import bfa_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] bitmap_mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sim/bitmap_frame_allocator_top_test.sv @@
// self-checking testbench for bitmap_frame_allocator_top: drives request words,
// predicts every response from its own copy of the frame bitmap and compares
// depends on bfa_pkg, bfa_if and the allocator rtl
`timescale 1ns / 100ps

module bitmap_frame_allocator_top_test;
   import bfa_pkg::*;

   localparam int BITMAP_WORDS    = 1024;
   localparam int TOTAL_FRAMES    = BITMAP_WORDS * WORD_BITS;
   localparam int POOL_FRAMES     = 256;
   localparam int RANDOM_ITEMS    = 560;
   localparam int SEED_ITEMS      = 40;
   localparam int CALM_ITEMS      = 80;
   localparam int PRESSURE_AT     = 150;
   localparam int PRESSURE_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 10000;

   typedef struct packed {
      logic [31:0] result_addr;
      logic [2:0]  status;
   } alloc_reply_type;

   class frame_ledger;
      logic [WORD_BITS-1:0] bitmap [BITMAP_WORDS];
      alloc_reply_type awaited[$];
      int errors;

      function new();
         foreach (bitmap[i]) bitmap[i] = FULL_WORD;
         errors = 0;
      endfunction

      function bit is_used(int unsigned frame);
         return bitmap[frame / WORD_BITS][frame % WORD_BITS];
      endfunction

      // apply one accepted request to the bitmap and queue the reply it must give
      function void note_request(logic [1:0] kind, logic [31:0] addr);
         alloc_reply_type reply;
         int unsigned frame, w, b;
         bit found;
         reply.result_addr = '0;
         reply.status = STATUS_OK;
         frame = addr >> FRAME_SHIFT;
         w = frame / WORD_BITS;
         b = frame % WORD_BITS;
         found = 1'b0;
         case (kind)
            REQ_ALLOC: begin
               for (int i = 0; i < BITMAP_WORDS && !found; i++) begin
                  if (bitmap[i] != FULL_WORD) begin
                     for (int j = 0; j < WORD_BITS && !found; j++) begin
                        if (!bitmap[i][j]) begin
                           bitmap[i][j] = 1'b1;
                           reply.result_addr = 32'((i * WORD_BITS + j) * FRAME_BYTES);
                           found = 1'b1;
                        end
                     end
                  end
               end
               if (!found) reply.status = STATUS_OOM;
            end
            REQ_FREE: begin
               // alignment is checked before range
               if (addr[FRAME_SHIFT-1:0] != '0) reply.status = STATUS_MISALIGNED;
               else if (frame >= TOTAL_FRAMES) reply.status = STATUS_RANGE;
               else if (!bitmap[w][b]) reply.status = STATUS_DOUBLE_FREE;
               else bitmap[w][b] = 1'b0;
            end
            default: begin
               if (frame >= TOTAL_FRAMES) reply.status = STATUS_RANGE;
               else bitmap[w][b] = (kind == REQ_MARK_USED);
            end
         endcase
         awaited.push_back(reply);
      endfunction

      function void check_reply(logic [31:0] addr, logic [2:0] status);
         alloc_reply_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected reply result_addr %h status %0d", $time, addr, status);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (addr !== want.result_addr) begin
            $display("%0t: result_addr expected %h actual %h", $time, want.result_addr, addr);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   bit   gaps_on;
   int   quiet_cycles;

   frame_ledger ledger = new();

   bfa_req_if req_ch ();
   bfa_rsp_if rsp_ch ();

   bitmap_frame_allocator_top #(
      .BITMAP_WORDS(BITMAP_WORDS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [31:0] frame_base(int unsigned frame);
      return 32'(frame) << FRAME_SHIFT;
   endfunction

   // mostly the low pool so allocs stay short, now and then anywhere in range
   function automatic int unsigned pick_frame();
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, TOTAL_FRAMES - 1);
      return $urandom_range(0, POOL_FRAMES - 1);
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [31:0] addr);
      if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.frame_addr <= addr;
      do @(posedge clock); while (!req_ch.ready);
      ledger.note_request(kind, addr);
   endtask

   // response side: random stalls plus one long hold-off to back the block up
   initial begin
      int idle_left;
      int replies_seen;
      bit hold_done;
      idle_left = 0;
      replies_seen = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            ledger.check_reply(rsp_ch.result_addr, rsp_ch.status);
            replies_seen++;
         end
         if (!hold_done && replies_seen == PRESSURE_AT) begin
            hold_done = 1'b1;
            idle_left = PRESSURE_CYCLES;
         end else if (idle_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 15);
         end
         if (idle_left > 0) begin
            rsp_ch.ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bitmap_frame_allocator_top_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned f;
      int pick;
      logic [1:0] kind;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_ALLOC;
      req_ch.frame_addr <= '0;
      calm    = 1'b0;
      gaps_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: everything starts in use
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_FREE, 32'h0000_0000);
      send_request(REQ_FREE, 32'h0000_0000);
      // frame zero handed out, address 0 with good status
      send_request(REQ_ALLOC, 32'hFFFF_FFFF);
      send_request(REQ_FREE, 32'h0000_0001);
      send_request(REQ_FREE, 32'hFFFF_F000);
      send_request(REQ_FREE, 32'hFFFF_FFFF);
      send_request(REQ_MARK_USED, 32'hFFFF_FFFF);
      send_request(REQ_MARK_FREE, frame_base(TOTAL_FRAMES));
      // last frame, unaligned address; alloc must scan the whole bitmap
      send_request(REQ_MARK_FREE, frame_base(TOTAL_FRAMES) - 1);
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_MARK_FREE, 32'h0000_5123);
      send_request(REQ_MARK_USED, 32'h0000_5FFF);
      send_request(REQ_FREE, 32'h0000_5000);
      send_request(REQ_MARK_FREE, 32'h0000_5000);
      send_request(REQ_ALLOC, 32'h0000_0000);
      // word boundary between bitmap words 0 and 1
      send_request(REQ_MARK_FREE, frame_base(31));
      send_request(REQ_MARK_FREE, frame_base(32));
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_MARK_FREE, frame_base(TOTAL_FRAMES - 1));
      send_request(REQ_FREE, frame_base(TOTAL_FRAMES - 1));
      send_request(REQ_MARK_USED, 32'h0000_0000);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         gaps_on = (n % 100) >= 30;
         pick = $urandom_range(0, 99);
         if (n < SEED_ITEMS) begin
            // hand the allocator some frames to work with
            send_request(REQ_MARK_FREE,
                         frame_base($urandom_range(0, POOL_FRAMES - 1)) |
                         32'($urandom_range(0, FRAME_BYTES - 1)));
         end else if (pick < 35) begin
            send_request(REQ_ALLOC, $urandom());
         end else if (pick < 60) begin
            f = pick_frame();
            if (pick < 52) begin
               for (int k = 0; k < 8 && !ledger.is_used(f); k++) f = pick_frame();
            end
            send_request(REQ_FREE, frame_base(f));
         end else if (pick < 75) begin
            send_request(REQ_MARK_FREE,
                         frame_base(pick_frame()) | 32'($urandom_range(0, FRAME_BYTES - 1)));
         end else if (pick < 85) begin
            send_request(REQ_MARK_USED,
                         frame_base(pick_frame()) | 32'($urandom_range(0, FRAME_BYTES - 1)));
         end else begin
            // noise: any address, mostly misaligned or out of range
            case ($urandom_range(0, 2))
               0: kind = REQ_FREE;
               1: kind = REQ_MARK_USED;
               default: kind = REQ_MARK_FREE;
            endcase
            send_request(kind, $urandom());
         end
      end
      req_ch.valid <= 1'b0;

      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (BITMAP_WORDS + 4) @(posedge clock);
      if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
         $display("bitmap_frame_allocator_top_test: clean");
      end else begin
         $display("bitmap_frame_allocator_top_test: errors");
      end
      $finish;
   end

endmodule

@@ bitmap_frame_allocator_top.f @@
+incdir+hdl
hdl/bfa_pkg.sv
hdl/bfa_if.sv
hdl/bfa_bitmap_ram.sv
hdl/bitmap_frame_allocator_top.sv
sim/bitmap_frame_allocator_top_test.sv
